### sv/grc_pkg.sv
package grc_pkg;

    // Grid store dimensions
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    // Scan looks at one aligned group of columns per cycle
    localparam int CHUNK   = (MAX_COLUMNS < 8) ? 2 : 8;
    localparam int CHUNK_W = $clog2(CHUNK);

    // Field widths fixed by the interface
    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    // Growth directions, tried in this order each round
    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               occupied;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_right;
        logic [COORD_W-1:0] rect_bottom;
    } result_t;

endpackage

### sv/grid_rectangle_cover.sv
// Write request: no result. Next request: one result beat. The scan reads each row, then tests
// it one 8-column group at a time; each growth direction is visited in turn; a column step
// tests each cell of the edge, then marks each cell; a row step tests the edge row in one read.
// One item at a time; busy is high from accept until the strobe; no receiver stall.
// Reset clears control state and the per-row valid bits of the covered store at once (no
// clearing pass); the occupancy store holds nothing defined until each cell is written.
module grid_rectangle_cover (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  grc_pkg::cmd_t                       cmd,
    output logic                                done,
    output grc_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  grc_pkg::cfg_reg_t                   cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]           cfg_data
);
    import grc_pkg::*;

    localparam int CW1 = COL_W + 1;
    localparam int RW1 = ROW_W + 1;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_SCAN_RD = 10'b00_0000_0010,
        ST_SCAN_EV = 10'b00_0000_0100,
        ST_GROW    = 10'b00_0000_1000,
        ST_COL_RD  = 10'b00_0001_0000,
        ST_COL_EV  = 10'b00_0010_0000,
        ST_MARK_RD = 10'b00_0100_0000,
        ST_MARK_EV = 10'b00_1000_0000,
        ST_ROW_RD  = 10'b01_0000_0000,
        ST_ROW_EV  = 10'b10_0000_0000
    } state_t;

    // Row-wide stores
    logic [MAX_COLUMNS-1:0] occ_mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] cov_mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] occ_q;
    logic [MAX_COLUMNS-1:0] cov_q;
    logic                   cov_vq;

    state_t                 state_reg, state_next;
    logic [RW1-1:0]         scan_row_reg, scan_row_next;
    logic [COL_W-1:0]       scan_col_reg, scan_col_next;
    logic [COL_W-1:0]       xmin_reg, xmin_next, xmax_reg, xmax_next;
    logic [ROW_W-1:0]       ymin_reg, ymin_next, ymax_reg, ymax_next;
    logic [COL_W-1:0]       tcol_reg, tcol_next;
    logic [ROW_W-1:0]       trow_reg, trow_next;
    logic [ROW_W-1:0]       rptr_reg, rptr_next;
    logic [3:0]             grow_reg, grow_next;
    dir_t                   dir_reg, dir_next;
    logic [CFG_W-1:0]       width_reg, height_reg;
    logic                   done_reg, done_next;
    result_t                result_reg, result_next;
    logic [MAX_ROWS-1:0]    cov_valid_reg, cov_valid_next;

    logic                   accept;
    logic                   occ_we;
    logic                   rd_en;
    logic [ROW_W-1:0]       rd_row;
    logic                   cov_we;
    logic [ROW_W-1:0]       cov_waddr;
    logic [MAX_COLUMNS-1:0] cov_wdata;
    logic                   clear_all;
    logic [CW1-1:0]         w_act;
    logic [RW1-1:0]         h_act;
    logic [MAX_COLUMNS-1:0] cov_eff;
    logic [MAX_COLUMNS-1:0] free_row;
    logic [MAX_COLUMNS-1:0] span_mask;
    logic [MAX_COLUMNS-1:0] tcol_bit;
    logic [MAX_COLUMNS-1:0] seed_bit;
    logic [CHUNK-1:0]       cand;
    logic [CHUNK_W-1:0]     cand_sel;
    logic [COL_W-1:0]       chunk_base;
    logic [CW1-1:0]         next_base;
    logic [COL_W-1:0]       seed_col;
    logic                   border_hit;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign occ_we    = accept && (cmd.req_type == REQ_WRITE)
                       && (int'(cmd.cell_x) < MAX_COLUMNS) && (int'(cmd.cell_y) < MAX_ROWS);

    // Active grid size, clamped to the store
    assign w_act = (int'(width_reg) > MAX_COLUMNS) ? CW1'(MAX_COLUMNS) : CW1'(width_reg);
    assign h_act = (int'(height_reg) > MAX_ROWS) ? RW1'(MAX_ROWS) : RW1'(height_reg);

    // Free cells of the row just read: occupied and not covered
    assign cov_eff  = cov_q & {MAX_COLUMNS{cov_vq}};
    assign free_row = occ_q & ~cov_eff;

    // Column masks for the current rectangle span and target column
    always_comb
    begin
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            span_mask[i] = (COL_W'(i) >= xmin_reg) && (COL_W'(i) <= xmax_reg);
            tcol_bit[i]  = (COL_W'(i) == tcol_reg);
            seed_bit[i]  = (COL_W'(i) == seed_col);
        end
    end

    // Scan candidates in the current column group, lowest one wins
    assign chunk_base = (scan_col_reg >> CHUNK_W) << CHUNK_W;
    assign next_base  = CW1'(chunk_base) + CW1'(CHUNK);

    always_comb
    begin
        logic [CW1-1:0] col;
        cand_sel = '0;
        for (int k = 0; k < CHUNK; k++)
        begin
            col     = CW1'(chunk_base) + CW1'(k);
            cand[k] = (col < w_act) && (col[COL_W-1:0] >= scan_col_reg)
                      && free_row[col[COL_W-1:0]];
        end
        for (int k = CHUNK - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                cand_sel = CHUNK_W'(k);
            end
        end
    end

    assign seed_col = chunk_base | COL_W'(cand_sel);

    // Border test for the current growth direction
    always_comb
    begin
        unique case (dir_reg)
            DIR_LEFT:  border_hit = (xmin_reg == '0);
            DIR_RIGHT: border_hit = (CW1'(xmax_reg) + CW1'(1) >= w_act);
            DIR_UP:    border_hit = (ymin_reg == '0);
            DIR_DOWN:  border_hit = (RW1'(ymax_reg) + RW1'(1) >= h_act);
            default:   border_hit = 1'b1;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        xmin_next      = xmin_reg;
        xmax_next      = xmax_reg;
        ymin_next      = ymin_reg;
        ymax_next      = ymax_reg;
        tcol_next      = tcol_reg;
        trow_next      = trow_reg;
        rptr_next      = rptr_reg;
        grow_next      = grow_reg;
        dir_next       = dir_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rd_en          = 1'b0;
        rd_row         = rptr_reg;
        cov_we         = 1'b0;
        cov_waddr      = rptr_reg;
        cov_wdata      = cov_eff | tcol_bit;
        clear_all      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.req_type == REQ_NEXT))
                begin
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_RD:
            begin
                if (scan_row_reg >= h_act)
                begin
                    // Scan end: drop all covered marks and restart
                    clear_all     = 1'b1;
                    scan_row_next = '0;
                    scan_col_next = '0;
                    done_next     = 1'b1;
                    result_next   = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_row     = scan_row_reg[ROW_W-1:0];
                    state_next = ST_SCAN_EV;
                end
            end

            ST_SCAN_EV:
            begin
                if (cand != '0)
                begin
                    // Seed found: mark it and start growing
                    cov_we    = 1'b1;
                    cov_waddr = scan_row_reg[ROW_W-1:0];
                    cov_wdata = cov_eff | seed_bit;
                    xmin_next = seed_col;
                    xmax_next = seed_col;
                    ymin_next = scan_row_reg[ROW_W-1:0];
                    ymax_next = scan_row_reg[ROW_W-1:0];
                    grow_next = 4'b1111;
                    dir_next  = DIR_LEFT;
                    if (int'(seed_col) == MAX_COLUMNS - 1)
                    begin
                        scan_row_next = scan_row_reg + RW1'(1);
                        scan_col_next = '0;
                    end
                    else
                    begin
                        scan_col_next = seed_col + COL_W'(1);
                    end
                    state_next = ST_GROW;
                end
                else if (next_base >= w_act)
                begin
                    scan_row_next = scan_row_reg + RW1'(1);
                    scan_col_next = '0;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    scan_col_next = next_base[COL_W-1:0];
                end
            end

            ST_GROW:
            begin
                if (grow_reg == '0)
                begin
                    done_next               = 1'b1;
                    result_next.found       = 1'b1;
                    result_next.rect_left   = COORD_W'(xmin_reg);
                    result_next.rect_top    = COORD_W'(ymin_reg);
                    result_next.rect_right  = COORD_W'(xmax_reg);
                    result_next.rect_bottom = COORD_W'(ymax_reg);
                    state_next              = ST_IDLE;
                end
                else if (!grow_reg[dir_reg])
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
                else if (border_hit)
                begin
                    grow_next[dir_reg] = 1'b0;
                    dir_next           = dir_t'(dir_reg + 2'd1);
                end
                else
                begin
                    unique case (dir_reg)
                        DIR_LEFT:
                        begin
                            tcol_next  = xmin_reg - COL_W'(1);
                            rptr_next  = ymin_reg;
                            state_next = ST_COL_RD;
                        end
                        DIR_RIGHT:
                        begin
                            tcol_next  = xmax_reg + COL_W'(1);
                            rptr_next  = ymin_reg;
                            state_next = ST_COL_RD;
                        end
                        DIR_UP:
                        begin
                            trow_next  = ymin_reg - ROW_W'(1);
                            state_next = ST_ROW_RD;
                        end
                        DIR_DOWN:
                        begin
                            trow_next  = ymax_reg + ROW_W'(1);
                            state_next = ST_ROW_RD;
                        end
                        default:
                        begin
                            state_next = ST_GROW;
                        end
                    endcase
                end
            end

            // Column step: test every row of the edge, then mark
            ST_COL_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_COL_EV;
            end

            ST_COL_EV:
            begin
                if (!free_row[tcol_reg])
                begin
                    grow_next[dir_reg] = 1'b0;
                    dir_next           = dir_t'(dir_reg + 2'd1);
                    state_next         = ST_GROW;
                end
                else if (rptr_reg == ymax_reg)
                begin
                    rptr_next  = ymin_reg;
                    state_next = ST_MARK_RD;
                end
                else
                begin
                    rptr_next  = rptr_reg + ROW_W'(1);
                    state_next = ST_COL_RD;
                end
            end

            ST_MARK_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_MARK_EV;
            end

            ST_MARK_EV:
            begin
                cov_we = 1'b1;
                if (rptr_reg == ymax_reg)
                begin
                    if (dir_reg == DIR_LEFT)
                    begin
                        xmin_next = tcol_reg;
                    end
                    else
                    begin
                        xmax_next = tcol_reg;
                    end
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_GROW;
                end
                else
                begin
                    rptr_next  = rptr_reg + ROW_W'(1);
                    state_next = ST_MARK_RD;
                end
            end

            // Row step: one read tests the whole edge, marked in place
            ST_ROW_RD:
            begin
                rd_en      = 1'b1;
                rd_row     = trow_reg;
                state_next = ST_ROW_EV;
            end

            ST_ROW_EV:
            begin
                cov_waddr = trow_reg;
                cov_wdata = cov_eff | span_mask;
                if ((free_row & span_mask) == span_mask)
                begin
                    cov_we = 1'b1;
                    if (dir_reg == DIR_UP)
                    begin
                        ymin_next = trow_reg;
                    end
                    else
                    begin
                        ymax_next = trow_reg;
                    end
                end
                else
                begin
                    grow_next[dir_reg] = 1'b0;
                end
                dir_next   = dir_t'(dir_reg + 2'd1);
                state_next = ST_GROW;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Covered-row valid bits
    always_comb
    begin
        cov_valid_next = cov_valid_reg;
        if (clear_all)
        begin
            cov_valid_next = '0;
        end
        if (cov_we)
        begin
            cov_valid_next[cov_waddr] = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            xmin_reg      <= '0;
            xmax_reg      <= '0;
            ymin_reg      <= '0;
            ymax_reg      <= '0;
            tcol_reg      <= '0;
            trow_reg      <= '0;
            rptr_reg      <= '0;
            grow_reg      <= '0;
            dir_reg       <= DIR_LEFT;
            width_reg     <= CFG_W'(64);
            height_reg    <= CFG_W'(64);
            done_reg      <= 1'b0;
            result_reg    <= '0;
            cov_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            xmin_reg      <= xmin_next;
            xmax_reg      <= xmax_next;
            ymin_reg      <= ymin_next;
            ymax_reg      <= ymax_next;
            tcol_reg      <= tcol_next;
            trow_reg      <= trow_next;
            rptr_reg      <= rptr_next;
            grow_reg      <= grow_next;
            dir_reg       <= dir_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
            cov_valid_reg <= cov_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  width_reg  <= cfg_data;
                    REG_GRID_HEIGHT: height_reg <= cfg_data;
                    default:         width_reg  <= width_reg;
                endcase
            end
        end
    end

    // Occupancy store: single-cell writes, row reads
    always_ff @(posedge clk)
    begin
        if (occ_we)
        begin
            occ_mem[cmd.cell_y[ROW_W-1:0]][cmd.cell_x[COL_W-1:0]] <= cmd.occupied;
        end
        if (rd_en)
        begin
            occ_q <= occ_mem[rd_row];
        end
    end

    // Covered store: row read-modify-write
    always_ff @(posedge clk)
    begin
        if (cov_we)
        begin
            cov_mem[cov_waddr] <= cov_wdata;
        end
        if (rd_en)
        begin
            cov_q  <= cov_mem[rd_row];
            cov_vq <= cov_valid_reg[rd_row];
        end
    end

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> (result.rect_left <= result.rect_right)
                                 && (result.rect_top <= result.rect_bottom))
        else $error("rectangle bounds out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> (result.rect_left == '0) && (result.rect_top == '0)
                                  && (result.rect_right == '0) && (result.rect_bottom == '0))
        else $error("scan end result has nonzero bounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> (cov_valid_reg == '0) && (scan_row_reg == '0))
        else $error("covered marks not cleared at scan end");

endmodule
